// ----- rtl/ubtt_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helpers for the uart bit-timed transceiver
// no dependencies
package ubtt_pkg;

    localparam int TICK_WIDTH  = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CNT_WIDTH   = 4;
    localparam int FRAME_BITS  = 11;
    localparam int RX_BITS     = 9;
    localparam int DATA_WIDTH  = 8;
    localparam int RX_TIMER_W  = TICK_WIDTH + 1;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_RX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_TX   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DRAIN  = 2'd3;

    localparam logic [CFG_WIDTH-1:0]  BIT_PERIOD_RESET = 16'd434;
    localparam logic [TICK_WIDTH-1:0] MIN_PERIOD       = TICK_WIDTH'(2);
    localparam logic [FRAME_BITS-1:0] TX_IDLE_FRAME    = '1;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] bit_period;
        logic                 invert_receive;
        logic                 invert_transmit;
        logic                 open_drain_transmit;
    } cfg_t;

    typedef struct packed {
        logic level;
        logic enable;
        logic busy;
    } tx_result_t;

    typedef struct packed {
        logic                  valid;
        logic [DATA_WIDTH-1:0] data;
    } rx_result_t;

    // bit period clipped to the tick width, with a floor of two ticks
    function automatic logic [TICK_WIDTH-1:0] eff_period(input logic [CFG_WIDTH-1:0] bp);
        logic [TICK_WIDTH-1:0] p;
        p = TICK_WIDTH'(bp);
        return (p < MIN_PERIOD) ? MIN_PERIOD : p;
    endfunction

endpackage

// ----- rtl/ubtt_tx.sv -----
`timescale 1ns / 1ps
// transmit frame shifter and bit timer, one tick per enabled cycle
// depends on ubtt_pkg
module ubtt_tx (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  ubtt_pkg::cfg_t                cfg,
    input  logic                          send_request,
    input  logic [ubtt_pkg::DATA_WIDTH-1:0] send_data,
    output ubtt_pkg::tx_result_t          result
);
    import ubtt_pkg::*;

    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [CNT_WIDTH-1:0]  bits_reg, bits_next;
    logic [TICK_WIDTH-1:0] timer_reg, timer_next;
    logic [TICK_WIDTH-1:0] period_m1;
    logic                  logic_bit;
    logic                  level;

    assign period_m1 = eff_period(cfg.bit_period) - TICK_WIDTH'(1);

    always_comb
    begin
        shift_next = shift_reg;
        bits_next  = bits_reg;
        timer_next = timer_reg;
        if (bits_reg != '0)
        begin
            if (timer_reg == '0)
            begin
                // shift in mark from the top
                shift_next = {1'b1, shift_reg[FRAME_BITS-1:1]};
                bits_next  = bits_reg - CNT_WIDTH'(1);
                timer_next = period_m1;
            end
            else
            begin
                timer_next = timer_reg - TICK_WIDTH'(1);
            end
        end
        if (bits_next == '0)
        begin
            shift_next = TX_IDLE_FRAME;
            if (send_request)
            begin
                // stop, data lsb first, start, idle mark in bit 0
                shift_next = {1'b1, send_data, 1'b0, 1'b1};
                bits_next  = CNT_WIDTH'(FRAME_BITS);
                timer_next = period_m1;
            end
        end
    end

    assign logic_bit = (bits_next != '0) ? shift_next[0] : 1'b1;
    assign level     = logic_bit ^ cfg.invert_transmit;

    always_comb
    begin
        result.busy = (bits_next != '0);
        if (cfg.open_drain_transmit)
        begin
            result.level  = 1'b0;
            result.enable = ~level;
        end
        else
        begin
            result.level  = level;
            result.enable = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= TX_IDLE_FRAME;
            bits_reg  <= '0;
            timer_reg <= '0;
        end
        else if (step)
        begin
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            timer_reg <= timer_next;
        end
    end

endmodule

// ----- rtl/ubtt_rx.sv -----
`timescale 1ns / 1ps
// receive start-edge detect, mid-bit sampler and byte assembly
// depends on ubtt_pkg
module ubtt_rx (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  ubtt_pkg::cfg_t       cfg,
    input  logic                 rx_line,
    output ubtt_pkg::rx_result_t result
);
    import ubtt_pkg::*;

    logic [RX_BITS-1:0]    shift_reg, shift_next;
    logic [CNT_WIDTH-1:0]  bits_reg, bits_next;
    logic [RX_TIMER_W-1:0] timer_reg, timer_next;
    logic [TICK_WIDTH-1:0] period;

    assign period = eff_period(cfg.bit_period);

    always_comb
    begin
        shift_next   = shift_reg;
        bits_next    = bits_reg;
        timer_next   = timer_reg;
        result.valid = 1'b0;
        result.data  = '0;
        if (bits_reg == '0)
        begin
            if ((rx_line ^ cfg.invert_receive) == 1'b0)
            begin
                // start edge: first sample lands mid data bit 0
                bits_next  = CNT_WIDTH'(RX_BITS);
                timer_next = RX_TIMER_W'(period >> 1) + RX_TIMER_W'(period);
                shift_next = '0;
            end
        end
        else if (timer_reg == '0)
        begin
            shift_next = {rx_line, shift_reg[RX_BITS-1:1]};
            bits_next  = bits_reg - CNT_WIDTH'(1);
            timer_next = RX_TIMER_W'(period) - RX_TIMER_W'(1);
            if (bits_next == '0)
            begin
                result.valid = 1'b1;
                result.data  = shift_next[DATA_WIDTH-1:0]
                               ^ {DATA_WIDTH{cfg.invert_receive}};
            end
        end
        else
        begin
            timer_next = timer_reg - RX_TIMER_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            bits_reg  <= '0;
            timer_reg <= '0;
        end
        else if (step)
        begin
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            timer_reg <= timer_next;
        end
    end

endmodule

// ----- rtl/uart_bit_timed_transceiver.sv -----
`timescale 1ns / 1ps
// uart 8n1 transceiver, one input beat per bit-timing tick
// path: from input accept to result beat through the input register, then the result register
// throughput: one beat per cycle while out_stall is low; the state update is one pass between the two registers
// reset: async active low; config returns to 434 ticks per bit, no inversion, push-pull,
// transmitter idle and receiver waiting for a start edge
// depends on ubtt_pkg, ubtt_tx, ubtt_rx
module uart_bit_timed_transceiver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ubtt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ubtt_pkg::CFG_WIDTH-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            rx_line,
    input  logic                            send_request,
    input  logic [ubtt_pkg::DATA_WIDTH-1:0] send_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            tx_level,
    output logic                            tx_enable,
    output logic                            tx_busy,
    output logic                            rx_valid,
    output logic [ubtt_pkg::DATA_WIDTH-1:0] rx_data
);
    import ubtt_pkg::*;

    cfg_t                  cfg_reg;
    logic                  in_full_reg;
    logic                  rx_line_reg;
    logic                  send_request_reg;
    logic [DATA_WIDTH-1:0] send_data_reg;
    logic                  out_full_reg;
    logic                  out_load;
    logic                  step;
    logic                  in_load;
    tx_result_t            tx_res;
    rx_result_t            rx_res;

    // result register can take a beat when empty or being drained
    assign out_load = ~out_full_reg | ~out_stall;
    assign step     = in_full_reg & out_load;
    assign in_stall = in_full_reg & ~out_load;
    assign in_load  = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period          <= BIT_PERIOD_RESET;
            cfg_reg.invert_receive      <= 1'b0;
            cfg_reg.invert_transmit     <= 1'b0;
            cfg_reg.open_drain_transmit <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BIT_PERIOD: cfg_reg.bit_period          <= cfg_data;
                CFG_INVERT_RX:  cfg_reg.invert_receive      <= cfg_data[0];
                CFG_INVERT_TX:  cfg_reg.invert_transmit     <= cfg_data[0];
                CFG_OPEN_DRAIN: cfg_reg.open_drain_transmit <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
                in_full_reg <= 1'b1;
            else if (step)
                in_full_reg <= 1'b0;
            if (out_load)
                out_full_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            rx_line_reg      <= rx_line;
            send_request_reg <= send_request;
            send_data_reg    <= send_data;
        end
        if (step)
        begin
            tx_level  <= tx_res.level;
            tx_enable <= tx_res.enable;
            tx_busy   <= tx_res.busy;
            rx_valid  <= rx_res.valid;
            rx_data   <= rx_res.data;
        end
    end

    assign out_valid = out_full_reg;

    ubtt_tx u_tx (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .cfg          (cfg_reg),
        .send_request (send_request_reg),
        .send_data    (send_data_reg),
        .result       (tx_res)
    );

    ubtt_rx u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .cfg     (cfg_reg),
        .rx_line (rx_line_reg),
        .result  (rx_res)
    );

endmodule
